### rtl/one_wire_master_slot_timer_core_assert.svh
// Assertion macros for the slot timer core checker.
`ifndef ONE_WIRE_MASTER_SLOT_TIMER_CORE_ASSERT_SVH
`define ONE_WIRE_MASTER_SLOT_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define OWM_ASSERT_NOW(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define OWM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle check failed");

`endif

### rtl/owm_pkg.sv
`timescale 1ns / 1ps

package owm_pkg;

   localparam int CFG_W         = 10;
   localparam int CFG_COUNT     = 8;
   localparam int CFG_IDX_W     = 3;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_COUNT_W   = 4;
   localparam int BYTE_W        = 8;

   localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW      = 3'd0;
   localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE       = 3'd1;
   localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL     = 3'd2;
   localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW       = 3'd3;
   localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE    = 3'd4;
   localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL      = 3'd5;
   localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WRITE    = 3'd6;
   localparam logic [CFG_IDX_W-1:0] CFG_LONG_WRITE     = 3'd7;

   localparam logic [CFG_W-1:0] RESET_LOW_DEFAULT      = 10'd485;
   localparam logic [CFG_W-1:0] PRESENCE_DEFAULT       = 10'd65;
   localparam logic [CFG_W-1:0] RESET_TAIL_DEFAULT     = 10'd500;
   localparam logic [CFG_W-1:0] READ_LOW_DEFAULT       = 10'd2;
   localparam logic [CFG_W-1:0] READ_SAMPLE_DEFAULT    = 10'd13;
   localparam logic [CFG_W-1:0] READ_TAIL_DEFAULT      = 10'd45;
   localparam logic [CFG_W-1:0] SHORT_WRITE_DEFAULT    = 10'd3;
   localparam logic [CFG_W-1:0] LONG_WRITE_DEFAULT     = 10'd65;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic               is_command;
      logic [BYTE_W-1:0]  data;
      logic               level;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

endpackage

### rtl/owm_front.sv
`timescale 1ns / 1ps

module owm_front
   import owm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_type,
   input  logic [BYTE_W-1:0]    req_write_data,
   input  logic                 req_bus_level,
   output queue_head_type       head,
   input  logic                 pop
);

   item_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   item_type    classified;
   logic        push;

   always_comb begin
      classified.data  = req_write_data;
      classified.level = req_bus_level;
      unique case (req_type)
         OP_RESET: begin
            classified.op         = OP_RESET;
            classified.is_command = 1'b1;
         end
         OP_WRITE: begin
            classified.op         = OP_WRITE;
            classified.is_command = 1'b1;
         end
         OP_READ: begin
            classified.op         = OP_READ;
            classified.is_command = 1'b1;
         end
         default: begin
            classified.op         = OP_TICK;
            classified.is_command = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

### rtl/owm_back.sv
`timescale 1ns / 1ps

module owm_back
   import owm_pkg::*;
#(
   parameter int BIT_GAP_TIME = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        head,
   output logic                  pop,
   input  logic                  csr_write_enable,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_drive_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_presence_missing,
   output logic [BYTE_W-1:0]     rsp_read_data,
   output logic                  rsp_rejected
);

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_WR_LOW   = 4'd4,
      PH_WR_HIGH  = 4'd5,
      PH_WR_GAP   = 4'd6,
      PH_RD_LOW   = 4'd7,
      PH_RD_WAIT  = 4'd8,
      PH_RD_TAIL  = 4'd9
   } phase_type;

   localparam logic [CFG_W-1:0] GAP_LEN =
      (BIT_GAP_TIME == 0) ? CFG_W'(1) : CFG_W'(BIT_GAP_TIME);
   localparam bit GAP_ENABLED = (BIT_GAP_TIME != 0);

   logic [CFG_W-1:0]        cfg_ff [CFG_COUNT];

   phase_type               phase_ff, phase_in;
   logic [CFG_W-1:0]        timer_ff, timer_in;
   logic [BIT_COUNT_W-1:0]  bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]       shift_ff, shift_in;
   logic                    presence_ff, presence_in;
   op_type                  op_ff, op_in;

   logic                    rsp_valid_ff;
   logic                    drive_low_ff, busy_ff, done_ff, rejected_ff;
   logic [BYTE_W-1:0]       read_data_ff;
   logic                    presence_out_ff;

   logic                    done, rejected;
   logic                    cur_bit;
   logic [CFG_W-1:0]        raw_len, phase_len;
   logic [CFG_W:0]          timer_sum;
   logic [BIT_COUNT_W-1:0]  bit_next;
   logic                    last_bit;

   assign pop = head.valid && (!rsp_valid_ff || !rsp_stall);

   assign cur_bit  = shift_ff[bit_count_ff[2:0]];
   assign bit_next = bit_count_ff + BIT_COUNT_W'(1);
   assign last_bit = (bit_next >= BIT_COUNT_W'(BITS_PER_BYTE));

   always_comb begin
      unique case (phase_ff)
         PH_RST_LOW:  raw_len = cfg_ff[CFG_RESET_LOW];
         PH_RST_WAIT: raw_len = cfg_ff[CFG_PRESENCE];
         PH_RST_TAIL: raw_len = cfg_ff[CFG_RESET_TAIL];
         PH_WR_LOW:   raw_len = cur_bit ? cfg_ff[CFG_SHORT_WRITE] : cfg_ff[CFG_LONG_WRITE];
         PH_WR_HIGH:  raw_len = cur_bit ? cfg_ff[CFG_LONG_WRITE] : cfg_ff[CFG_SHORT_WRITE];
         PH_WR_GAP:   raw_len = GAP_LEN;
         PH_RD_LOW:   raw_len = cfg_ff[CFG_READ_LOW];
         PH_RD_WAIT:  raw_len = cfg_ff[CFG_READ_SAMPLE];
         PH_RD_TAIL:  raw_len = cfg_ff[CFG_READ_TAIL];
         default:     raw_len = CFG_W'(1);
      endcase
      phase_len = (raw_len == '0) ? CFG_W'(1) : raw_len;
   end

   assign timer_sum = {1'b0, timer_ff} + (CFG_W+1)'(1);

   always_comb begin
      phase_in     = phase_ff;
      timer_in     = timer_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      presence_in  = presence_ff;
      op_in        = op_ff;
      done         = 1'b0;
      rejected     = 1'b0;
      if (!head.item.is_command) begin
         if (phase_ff != PH_IDLE) begin
            if (timer_sum >= {1'b0, phase_len}) begin
               timer_in = '0;
               unique case (phase_ff)
                  PH_RST_LOW:  phase_in = PH_RST_WAIT;
                  PH_RST_WAIT: begin
                     presence_in = head.item.level;
                     phase_in    = PH_RST_TAIL;
                  end
                  PH_RST_TAIL: begin
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
                  PH_WR_LOW:   phase_in = PH_WR_HIGH;
                  PH_WR_HIGH, PH_WR_GAP: begin
                     if (GAP_ENABLED && phase_ff == PH_WR_HIGH) begin
                        phase_in = PH_WR_GAP;
                     end else begin
                        bit_count_in = bit_next;
                        phase_in     = last_bit ? PH_IDLE : PH_WR_LOW;
                        done         = last_bit;
                     end
                  end
                  PH_RD_LOW:   phase_in = PH_RD_WAIT;
                  PH_RD_WAIT: begin
                     shift_in[bit_count_ff[2:0]] = shift_ff[bit_count_ff[2:0]] | head.item.level;
                     phase_in = PH_RD_TAIL;
                  end
                  PH_RD_TAIL: begin
                     bit_count_in = bit_next;
                     phase_in     = last_bit ? PH_IDLE : PH_RD_LOW;
                     done         = last_bit;
                  end
                  default:     phase_in = PH_IDLE;
               endcase
            end else begin
               timer_in = timer_sum[CFG_W-1:0];
            end
         end
      end else if (phase_ff != PH_IDLE) begin
         rejected = 1'b1;
      end else begin
         op_in        = head.item.op;
         timer_in     = '0;
         bit_count_in = '0;
         unique case (head.item.op)
            OP_RESET: phase_in = PH_RST_LOW;
            OP_WRITE: begin
               shift_in = head.item.data;
               phase_in = PH_WR_LOW;
            end
            OP_READ: begin
               shift_in = '0;
               phase_in = PH_RD_LOW;
            end
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         presence_ff  <= 1'b1;
         op_ff        <= OP_TICK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff        <= phase_in;
            timer_ff        <= timer_in;
            bit_count_ff    <= bit_count_in;
            shift_ff        <= shift_in;
            presence_ff     <= presence_in;
            op_ff           <= op_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff    <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         drive_low_ff    <= (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW)
                            || (phase_in == PH_RD_LOW);
         busy_ff         <= (phase_in != PH_IDLE);
         done_ff         <= done;
         presence_out_ff <= presence_in;
         read_data_ff    <= (op_in == OP_READ) ? shift_in : '0;
         rejected_ff     <= rejected;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CFG_RESET_LOW]   <= RESET_LOW_DEFAULT;
         cfg_ff[CFG_PRESENCE]    <= PRESENCE_DEFAULT;
         cfg_ff[CFG_RESET_TAIL]  <= RESET_TAIL_DEFAULT;
         cfg_ff[CFG_READ_LOW]    <= READ_LOW_DEFAULT;
         cfg_ff[CFG_READ_SAMPLE] <= READ_SAMPLE_DEFAULT;
         cfg_ff[CFG_READ_TAIL]   <= READ_TAIL_DEFAULT;
         cfg_ff[CFG_SHORT_WRITE] <= SHORT_WRITE_DEFAULT;
         cfg_ff[CFG_LONG_WRITE]  <= LONG_WRITE_DEFAULT;
      end else if (csr_write_enable) begin
         cfg_ff[csr_index] <= csr_write_data;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_drive_low        = drive_low_ff;
   assign rsp_busy_res         = busy_ff;
   assign rsp_done_res         = done_ff;
   assign rsp_presence_missing = presence_out_ff;
   assign rsp_read_data        = read_data_ff;
   assign rsp_rejected         = rejected_ff;

endmodule

### rtl/one_wire_master_slot_timer_core.sv
`timescale 1ns / 1ps
// One-wire bus master slot timer.
// Request channel (req_valid / req_stall): each transfer is a tick of one
// microsecond (carrying the sampled bus level) or a reset, write-byte or
// read-byte command (write byte carries req_write_data).
// Response channel (rsp_valid / rsp_stall): exactly one transfer per request,
// in order, giving drive_low, busy, done, presence, read data and rejected.
// A response leaves the back-end response register after its request has
// passed the front-end queue. Throughput: one request per cycle while
// rsp_stall is low; the back end updates timer and phase on each pop.
// The front end holds a two-entry request queue that feeds the back end;
// when rsp_stall holds the response register, the queue fills and req_stall
// rises once both entries are taken.
// Configuration (csr_write_enable / csr_index / csr_write_data) loads the
// eight timing registers; write only while no request is outstanding.
// Reset (synchronous, active high) empties the queue, drops rsp_valid,
// returns the sequencer to idle and loads the default timings.
module one_wire_master_slot_timer_core
   import owm_pkg::*;
#(
   parameter int BIT_GAP_TIME = 5
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_type,
   input  logic [BYTE_W-1:0]     req_write_data,
   input  logic                  req_bus_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_drive_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_presence_missing,
   output logic [BYTE_W-1:0]     rsp_read_data,
   output logic                  rsp_rejected,
   input  logic                  csr_write_enable,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_write_data
);

   queue_head_type head;
   logic           pop;

   owm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_write_data (req_write_data),
      .req_bus_level  (req_bus_level),
      .head           (head),
      .pop            (pop)
   );

   owm_back #(
      .BIT_GAP_TIME (BIT_GAP_TIME)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head                 (head),
      .pop                  (pop),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_drive_low        (rsp_drive_low),
      .rsp_busy_res         (rsp_busy_res),
      .rsp_done_res         (rsp_done_res),
      .rsp_presence_missing (rsp_presence_missing),
      .rsp_read_data        (rsp_read_data),
      .rsp_rejected         (rsp_rejected)
   );

endmodule

### rtl/owm_checker.sv
`timescale 1ns / 1ps
`include "one_wire_master_slot_timer_core_assert.svh"

module owm_checker
   import owm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_drive_low,
   input  logic                  rsp_busy_res,
   input  logic                  rsp_done_res,
   input  logic                  rsp_presence_missing,
   input  logic [BYTE_W-1:0]     rsp_read_data,
   input  logic                  rsp_rejected
);

   logic [BYTE_W+4:0] rsp_payload;

   assign rsp_payload = {rsp_drive_low, rsp_busy_res, rsp_done_res, rsp_presence_missing,
                         rsp_read_data, rsp_rejected};

   `OWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))
   `OWM_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res && !rsp_rejected)
   `OWM_ASSERT_NOW(a_reject_busy, clock, reset, rsp_valid && rsp_rejected, rsp_busy_res)
   `OWM_ASSERT_NOW(a_drive_busy, clock, reset, rsp_valid && rsp_drive_low, rsp_busy_res)

endmodule

bind one_wire_master_slot_timer_core owm_checker u_owm_checker (.*);

### bench/tb_one_wire_master_slot_timer_core.sv
`timescale 1ns / 1ps

module tb_one_wire_master_slot_timer_core;
   import owm_pkg::*;

   localparam int GAP_TICKS   = 5;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int HOLD_START  = 500;
   localparam int HOLD_CYCLES = 80;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RESET_PULSE,
      ST_PRESENCE_WAIT,
      ST_RESET_RECOVER,
      ST_WRITE_LOW,
      ST_WRITE_RELEASE,
      ST_WRITE_GAP,
      ST_READ_LOW,
      ST_READ_SAMPLE,
      ST_READ_RECOVER
   } slot_state_type;

   typedef struct {
      op_type            op;
      logic [BYTE_W-1:0] data;
      logic              level;
   } bus_request_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy;
      logic              done;
      logic              presence_missing;
      logic [BYTE_W-1:0] read_data;
      logic              rejected;
   } line_status_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic [1:0]           req_type         = OP_TICK;
   logic [BYTE_W-1:0]    req_write_data   = '0;
   logic                 req_bus_level    = 1'b1;
   logic                 rsp_stall        = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index        = '0;
   logic [CFG_W-1:0]     csr_write_data   = '0;

   logic              req_stall;
   logic              rsp_valid;
   logic              rsp_drive_low;
   logic              rsp_busy_res;
   logic              rsp_done_res;
   logic              rsp_presence_missing;
   logic [BYTE_W-1:0] rsp_read_data;
   logic              rsp_rejected;

   bus_request_type request_queue[$];
   line_status_type awaiting_status[$];

   slot_state_type    slot_state;
   logic [10:0]       tick_count;
   logic [3:0]        bit_idx;
   logic [BYTE_W-1:0] shift_reg;
   logic              presence_flag;
   op_type            last_op;
   logic [CFG_W-1:0]  cfg_regs [CFG_COUNT];

   int  fail_count  = 0;
   int  cycle_count = 0;
   int  plan_left   = 0;
   int  gap_left    = 0;
   int  stall_left  = 0;
   int  hold_left   = 0;
   int  send_pct    = 0;
   int  stall_pct   = 0;
   bit  hold_done   = 1'b0;
   bit  calm        = 1'b0;
   bit  req_taken   = 1'b0;

   one_wire_master_slot_timer_core #(
      .BIT_GAP_TIME(GAP_TICKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_write_data(req_write_data),
      .req_bus_level(req_bus_level),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive_low(rsp_drive_low),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_presence_missing(rsp_presence_missing),
      .rsp_read_data(rsp_read_data),
      .rsp_rejected(rsp_rejected),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int min_one(input logic [CFG_W-1:0] v);
      return (v == '0) ? 1 : int'(v);
   endfunction

   function automatic int slot_span();
      logic cur;
      cur = shift_reg[bit_idx[2:0]];
      case (slot_state)
         ST_RESET_PULSE:   return min_one(cfg_regs[CFG_RESET_LOW]);
         ST_PRESENCE_WAIT: return min_one(cfg_regs[CFG_PRESENCE]);
         ST_RESET_RECOVER: return min_one(cfg_regs[CFG_RESET_TAIL]);
         ST_WRITE_LOW:
            return min_one(cur ? cfg_regs[CFG_SHORT_WRITE] : cfg_regs[CFG_LONG_WRITE]);
         ST_WRITE_RELEASE:
            return min_one(cur ? cfg_regs[CFG_LONG_WRITE] : cfg_regs[CFG_SHORT_WRITE]);
         ST_WRITE_GAP:     return (GAP_TICKS == 0) ? 1 : GAP_TICKS;
         ST_READ_LOW:      return min_one(cfg_regs[CFG_READ_LOW]);
         ST_READ_SAMPLE:   return min_one(cfg_regs[CFG_READ_SAMPLE]);
         ST_READ_RECOVER:  return min_one(cfg_regs[CFG_READ_TAIL]);
         default:          return 1;
      endcase
   endfunction

   task automatic predict_line_status(input bus_request_type rq);
      line_status_type st;
      logic            finished;
      logic            slot_over;
      slot_state_type  restart;
      finished  = 1'b0;
      slot_over = 1'b0;
      restart   = ST_IDLE;
      st.rejected = 1'b0;
      if (rq.op == OP_TICK) begin
         if (slot_state != ST_IDLE) begin
            tick_count = tick_count + 11'd1;
            if (int'(tick_count) >= slot_span()) begin
               tick_count = '0;
               case (slot_state)
                  ST_RESET_PULSE: slot_state = ST_PRESENCE_WAIT;
                  ST_PRESENCE_WAIT: begin
                     presence_flag = rq.level;
                     slot_state = ST_RESET_RECOVER;
                  end
                  ST_RESET_RECOVER: begin
                     slot_state = ST_IDLE;
                     finished = 1'b1;
                  end
                  ST_WRITE_LOW: slot_state = ST_WRITE_RELEASE;
                  ST_WRITE_RELEASE: begin
                     if (GAP_TICKS != 0) begin
                        slot_state = ST_WRITE_GAP;
                     end else begin
                        slot_over = 1'b1;
                        restart = ST_WRITE_LOW;
                     end
                  end
                  ST_WRITE_GAP: begin
                     slot_over = 1'b1;
                     restart = ST_WRITE_LOW;
                  end
                  ST_READ_LOW: slot_state = ST_READ_SAMPLE;
                  ST_READ_SAMPLE: begin
                     shift_reg[bit_idx[2:0]] = shift_reg[bit_idx[2:0]] | rq.level;
                     slot_state = ST_READ_RECOVER;
                  end
                  ST_READ_RECOVER: begin
                     slot_over = 1'b1;
                     restart = ST_READ_LOW;
                  end
                  default: slot_state = ST_IDLE;
               endcase
               if (slot_over) begin
                  bit_idx = bit_idx + 4'd1;
                  if (bit_idx >= BITS_PER_BYTE) begin
                     slot_state = ST_IDLE;
                     finished = 1'b1;
                  end else begin
                     slot_state = restart;
                  end
               end
            end
         end
      end else if (slot_state != ST_IDLE) begin
         st.rejected = 1'b1;
      end else begin
         last_op = rq.op;
         tick_count = '0;
         bit_idx = '0;
         case (rq.op)
            OP_RESET: slot_state = ST_RESET_PULSE;
            OP_WRITE: begin
               shift_reg = rq.data;
               slot_state = ST_WRITE_LOW;
            end
            default: begin
               shift_reg = '0;
               slot_state = ST_READ_LOW;
            end
         endcase
      end
      st.drive_low = (slot_state == ST_RESET_PULSE || slot_state == ST_WRITE_LOW ||
                      slot_state == ST_READ_LOW);
      st.busy = (slot_state != ST_IDLE);
      st.done = finished;
      st.presence_missing = presence_flag;
      st.read_data = (last_op == OP_READ) ? shift_reg : '0;
      awaiting_status.push_back(st);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_transfers
      line_status_type want;
      if (reset) begin
         slot_state    = ST_IDLE;
         tick_count    = '0;
         bit_idx       = '0;
         shift_reg     = '0;
         presence_flag = 1'b1;
         last_op       = OP_TICK;
         cfg_regs[CFG_RESET_LOW]   = RESET_LOW_DEFAULT;
         cfg_regs[CFG_PRESENCE]    = PRESENCE_DEFAULT;
         cfg_regs[CFG_RESET_TAIL]  = RESET_TAIL_DEFAULT;
         cfg_regs[CFG_READ_LOW]    = READ_LOW_DEFAULT;
         cfg_regs[CFG_READ_SAMPLE] = READ_SAMPLE_DEFAULT;
         cfg_regs[CFG_READ_TAIL]   = READ_TAIL_DEFAULT;
         cfg_regs[CFG_SHORT_WRITE] = SHORT_WRITE_DEFAULT;
         cfg_regs[CFG_LONG_WRITE]  = LONG_WRITE_DEFAULT;
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaiting_status.size() == 0) begin
               $error("response transfer with nothing expected");
               fail_count++;
            end else begin
               want = awaiting_status.pop_front();
               check_field("drive_low", want.drive_low, rsp_drive_low);
               check_field("busy_res", want.busy, rsp_busy_res);
               check_field("done_res", want.done, rsp_done_res);
               check_field("presence_missing", want.presence_missing, rsp_presence_missing);
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("rejected", want.rejected, rsp_rejected);
            end
         end
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            predict_line_status('{op_type'(req_type), req_write_data, req_bus_level});
         end
         if (csr_write_enable) begin
            cfg_regs[csr_index] = csr_write_data;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count = cycle_count + 1;
      if (cycle_count % 400 == 0) begin
         case ($urandom_range(0, 2))
            0:       send_pct = 0;
            1:       send_pct = 5;
            default: send_pct = 20;
         endcase
         case ($urandom_range(0, 2))
            0:       stall_pct = 0;
            1:       stall_pct = 5;
            default: stall_pct = 20;
         endcase
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_one_wire_master_slot_timer_core: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin : drive_requests
      bus_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold until the transfer completes
      end else if (gap_left > 0) begin
         gap_left = gap_left - 1;
         req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < send_pct) begin
         gap_left = $urandom_range(0, 9);
         req_valid <= 1'b0;
      end else if (request_queue.size() != 0) begin
         next_req = request_queue.pop_front();
         req_valid      <= 1'b1;
         req_type       <= next_req.op;
         req_write_data <= next_req.data;
         req_bus_level  <= next_req.level;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin : drive_stall
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && cycle_count >= HOLD_START) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int command_ticks(input op_type op);
      case (op)
         OP_RESET:
            return min_one(cfg_regs[CFG_RESET_LOW]) + min_one(cfg_regs[CFG_PRESENCE]) +
                   min_one(cfg_regs[CFG_RESET_TAIL]);
         OP_WRITE:
            return BITS_PER_BYTE * (min_one(cfg_regs[CFG_SHORT_WRITE]) +
                   min_one(cfg_regs[CFG_LONG_WRITE]) + GAP_TICKS);
         OP_READ:
            return BITS_PER_BYTE * (min_one(cfg_regs[CFG_READ_LOW]) +
                   min_one(cfg_regs[CFG_READ_SAMPLE]) + min_one(cfg_regs[CFG_READ_TAIL]));
         default: return 0;
      endcase
   endfunction

   task automatic push_request(input op_type op, input logic [BYTE_W-1:0] data,
                               input logic level);
      request_queue.push_back('{op, data, level});
      if (op == OP_TICK) begin
         if (plan_left > 0) plan_left = plan_left - 1;
      end else if (plan_left == 0) begin
         plan_left = command_ticks(op);
      end
   endtask

   // level mode: 0 low, 1 high, 2 random
   task automatic finish_command(input int mode);
      logic lvl;
      while (plan_left > 0) begin
         lvl = (mode == 2) ? 1'($urandom_range(0, 1)) : (mode == 1);
         push_request(OP_TICK, BYTE_W'($urandom), lvl);
      end
   endtask

   task automatic random_traffic(input int amount);
      int issued;
      issued = 0;
      while (issued < amount) begin
         if (plan_left == 0) begin
            if ($urandom_range(0, 9) < 8) begin
               push_request(op_type'($urandom_range(1, 3)), BYTE_W'($urandom), 1'($urandom));
               issued++;
               if ($urandom_range(0, 9) == 0) begin
                  push_request(op_type'($urandom_range(1, 3)), BYTE_W'($urandom),
                               1'($urandom));
                  issued++;
               end
            end else begin
               push_request(OP_TICK, BYTE_W'($urandom), 1'($urandom));
            end
         end else begin
            if ($urandom_range(0, 31) == 0) begin
               push_request(op_type'($urandom_range(1, 3)), BYTE_W'($urandom), 1'($urandom));
            end else begin
               push_request(OP_TICK, BYTE_W'($urandom), 1'($urandom));
            end
            issued++;
         end
      end
      finish_command(2);
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (request_queue.size() != 0 || req_valid || awaiting_status.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_timing(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= v;
      @(negedge clock);
   endtask

   task automatic program_timings(input logic [CFG_W-1:0] rl, ps, rt, rdl, rds, rdt, sw, lw);
      write_timing(CFG_RESET_LOW, rl);
      write_timing(CFG_PRESENCE, ps);
      write_timing(CFG_RESET_TAIL, rt);
      write_timing(CFG_READ_LOW, rdl);
      write_timing(CFG_READ_SAMPLE, rds);
      write_timing(CFG_READ_TAIL, rdt);
      write_timing(CFG_SHORT_WRITE, sw);
      write_timing(CFG_LONG_WRITE, lw);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CFG_W-1:0] pick_time(input int hi);
      if ($urandom_range(0, 7) == 0) return '0;
      return CFG_W'($urandom_range(1, hi));
   endfunction

   initial begin : run_phases
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_request(OP_TICK, 8'hFF, 1'b1);
      push_request(OP_READ, 8'h00, 1'b0);
      finish_command(2);
      push_request(OP_WRITE, 8'h5A, 1'b0);
      repeat (60) push_request(OP_TICK, BYTE_W'($urandom), 1'b1);
      push_request(OP_RESET, 8'hFF, 1'b1);
      wait_quiet();

      // shorten the write still on the bus
      program_timings(1, 1, 1, 1, 1, 1, 1, 1);
      plan_left = command_ticks(OP_WRITE);
      finish_command(2);
      push_request(OP_RESET, 8'h00, 1'b0);
      finish_command(0);
      push_request(OP_RESET, 8'hFF, 1'b1);
      finish_command(1);
      random_traffic(120);
      wait_quiet();

      program_timings(0, 0, 0, 0, 0, 0, 0, 0);
      random_traffic(80);
      wait_quiet();

      repeat (3) begin
         program_timings(pick_time(6), pick_time(6), pick_time(6), pick_time(6),
                         pick_time(6), pick_time(6), pick_time(6), pick_time(6));
         random_traffic(80);
         wait_quiet();
      end

      calm = 1'b1;
      program_timings(pick_time(12), pick_time(12), pick_time(12), pick_time(12),
                      pick_time(12), pick_time(12), pick_time(12), pick_time(12));
      random_traffic(100);
      wait_quiet();

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_one_wire_master_slot_timer_core: PASS");
      end else begin
         $display("tb_one_wire_master_slot_timer_core: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/owm_pkg.sv
rtl/owm_front.sv
rtl/owm_back.sv
rtl/one_wire_master_slot_timer_core.sv
rtl/owm_checker.sv
bench/tb_one_wire_master_slot_timer_core.sv
